FILE: rtl/os_timer_match_unit_defines.svh
// Assertion macros shared by the timer RTL.
// Included by os_timer_match_unit.sv; needs no other file.
`ifndef OS_TIMER_MATCH_UNIT_DEFINES_SVH
`define OS_TIMER_MATCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define OTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("timer assertion failed");
`define OTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("timer assertion failed");
`else
`define OTM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define OTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/otm_pkg.sv
// Types and constants for the operating-system timer with four match channels.
// Has no dependencies; used by os_timer_match_unit.sv.
`timescale 1ns / 1ps
package otm_pkg;
	localparam int NUM_CH = 4;
	localparam int DATA_W = 32;
	localparam int OFF_W = 14;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic [2:0] ACCESS_WORD = 3'd4;

	localparam logic [OFF_W-1:0] OFF_MATCH0 = 14'd0;
	localparam logic [OFF_W-1:0] OFF_MATCH3 = 14'd3;
	localparam logic [OFF_W-1:0] OFF_COUNTER = 14'd4;
	localparam logic [OFF_W-1:0] OFF_STATUS = 14'd5;
	localparam logic [OFF_W-1:0] OFF_WDOG = 14'd6;
	localparam logic [OFF_W-1:0] OFF_IRQ_EN = 14'd7;

	typedef struct packed {
		logic [1:0]        command;
		logic [OFF_W-1:0]  word_offset;
		logic [2:0]        access_bytes;
		logic [DATA_W-1:0] write_data;
	} request_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              access_ok;
		logic [NUM_CH-1:0] irq_lines;
	} response_t;
endpackage

FILE: rtl/os_timer_match_unit.sv
// Channel   | Handshake         | Word
// request   | start, busy       | otm_pkg::request_t (tick, register read or write)
// response  | done              | otm_pkg::response_t (read data, status, interrupts)
// An accepted word is registered, processed in the following cycle and its response is
// shown on response with done high in the cycle after that.
// A new word is taken in every cycle, since busy stays low; the state is updated at the
// same edge as the response register, so each word sees the result of the one before.
// Reset clears the counter, match, status and enable registers at once.
// The receiver cannot stall; every response is valid for exactly one cycle.
// Depends on otm_pkg.sv and os_timer_match_unit_defines.svh.
`timescale 1ns / 1ps
`include "os_timer_match_unit_defines.svh"
module os_timer_match_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  otm_pkg::request_t   request,
	output logic                done,
	output otm_pkg::response_t  response
);
	logic                                  valid_s1;
	otm_pkg::request_t                     req_s1;
	logic [otm_pkg::DATA_W-1:0]            match_q [otm_pkg::NUM_CH];
	logic [otm_pkg::DATA_W-1:0]            counter_q;
	logic [otm_pkg::NUM_CH-1:0]            status_q;
	logic [7:0]                            irq_en_q;
	logic [7:0]                            wdog_q;

	logic [otm_pkg::DATA_W-1:0]            match_n [otm_pkg::NUM_CH];
	logic [otm_pkg::DATA_W-1:0]            counter_n;
	logic [otm_pkg::NUM_CH-1:0]            status_n;
	logic [otm_pkg::NUM_CH-1:0]            status_fin;
	logic [otm_pkg::NUM_CH-1:0]            hit;
	logic [7:0]                            irq_en_n;
	logic [7:0]                            wdog_n;
	logic [otm_pkg::DATA_W-1:0]            rd_c;
	logic                                  ok_c;
	logic                                  check_c;
	logic                                  size_ok;
	logic [1:0]                            idx;

	assign busy = 1'b0;
	assign size_ok = (req_s1.access_bytes == otm_pkg::ACCESS_WORD);
	assign idx = req_s1.word_offset[1:0];

	always_comb begin
		match_n = match_q;
		counter_n = counter_q;
		status_n = status_q;
		irq_en_n = irq_en_q;
		wdog_n = wdog_q;
		rd_c = '0;
		ok_c = 1'b1;
		check_c = 1'b0;
		unique case (req_s1.command)
			otm_pkg::CMD_TICK: begin
				counter_n = counter_q + 32'd1;
				check_c = 1'b1;
			end
			otm_pkg::CMD_READ: begin
				if (!size_ok) begin
					ok_c = 1'b0;
				end else begin
					case (req_s1.word_offset) inside
						[otm_pkg::OFF_MATCH0:otm_pkg::OFF_MATCH3]: rd_c = match_q[idx];
						otm_pkg::OFF_COUNTER: rd_c = counter_q;
						otm_pkg::OFF_STATUS:  rd_c = {28'd0, status_q};
						otm_pkg::OFF_WDOG:    rd_c = {24'd0, wdog_q};
						otm_pkg::OFF_IRQ_EN:  rd_c = {24'd0, irq_en_q};
						default:              rd_c = '0;
					endcase
				end
			end
			otm_pkg::CMD_WRITE: begin
				if (!size_ok) begin
					ok_c = 1'b0;
				end else begin
					case (req_s1.word_offset) inside
						[otm_pkg::OFF_MATCH0:otm_pkg::OFF_MATCH3]: begin
							match_n[idx] = req_s1.write_data;
							check_c = 1'b1;
						end
						otm_pkg::OFF_COUNTER: counter_n = req_s1.write_data;
						otm_pkg::OFF_STATUS: begin
							status_n = status_q & ~req_s1.write_data[otm_pkg::NUM_CH-1:0];
							check_c = 1'b1;
						end
						otm_pkg::OFF_WDOG: begin
							if (req_s1.write_data[0]) begin
								ok_c = 1'b0;
							end else begin
								wdog_n = req_s1.write_data[7:0];
							end
						end
						otm_pkg::OFF_IRQ_EN: begin
							irq_en_n = req_s1.write_data[7:0];
							check_c = 1'b1;
						end
						default: ;
					endcase
				end
			end
			default: ok_c = 1'b0;
		endcase
		for (int ch = 0; ch < otm_pkg::NUM_CH; ch++) begin
			hit[ch] = (counter_n == match_n[ch]) && irq_en_n[ch];
		end
		status_fin = check_c ? (status_n | hit) : status_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done <= 1'b0;
			counter_q <= '0;
			status_q <= '0;
			irq_en_q <= '0;
			wdog_q <= '0;
			for (int ch = 0; ch < otm_pkg::NUM_CH; ch++) begin
				match_q[ch] <= '0;
			end
		end else begin
			valid_s1 <= start && !busy;
			done <= valid_s1;
			if (valid_s1) begin
				counter_q <= counter_n;
				status_q <= status_fin;
				irq_en_q <= irq_en_n;
				wdog_q <= wdog_n;
				match_q <= match_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
		if (valid_s1) begin
			response.read_data <= rd_c;
			response.access_ok <= ok_c;
			response.irq_lines <= status_fin;
		end
	end

	`OTM_ASSERT_NEXT(a_word_answered, clk, arst_n, valid_s1, done)
	`OTM_ASSERT_SAME(a_irq_matches_status, clk, arst_n, done, response.irq_lines == status_q)
	`OTM_ASSERT_SAME(a_failed_reads_zero, clk, arst_n, done && !response.access_ok,
		response.read_data == '0)
	`OTM_ASSERT_NEXT(a_failed_keeps_counter, clk, arst_n, valid_s1 && !ok_c,
		$stable(counter_q))
	`OTM_ASSERT_NEXT(a_status_sticky, clk, arst_n,
		valid_s1 && !(req_s1.command == otm_pkg::CMD_WRITE
			&& req_s1.word_offset == otm_pkg::OFF_STATUS),
		(status_q & $past(status_q)) == $past(status_q))
endmodule
